FILE: rtl/core/oaht_pkg.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table: shared definitions
// Field widths, operation and status codes, slot marks and parameter defaults.
// ----------------------------------------------------------------------------
package oaht_pkg;

   // Fixed field widths of the request and response words and the slot mark
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 32;
   localparam int HASH_W   = 32;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 9;
   localparam int MARK_W   = 2;

   // Parameter defaults for the top level
   localparam int TABLE_SLOTS_DEFAULT = 256;
   localparam int KEY_BITS_DEFAULT    = 32;
   localparam int VALUE_BITS_DEFAULT  = 32;

   // Perturb shift per probe step
   localparam int PERTURB_SHIFT = 5;

   // Request operations
   localparam logic [ACTION_W-1:0] ACT_GET    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // Slot marks
   localparam logic [MARK_W-1:0] MARK_FREE  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_TAKEN = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

endpackage

FILE: rtl/core/oaht_if.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table: channel interfaces
// Valid/ready channels for the request word and the response word.
// ----------------------------------------------------------------------------

// Request channel: get, set or delete of one key
interface oaht_req_if;
   logic                           valid;
   logic                           ready;
   logic [oaht_pkg::ACTION_W-1:0]  action;
   logic [oaht_pkg::KEY_W-1:0]     key;
   logic [oaht_pkg::HASH_W-1:0]    key_hash;
   logic [oaht_pkg::VALUE_W-1:0]   new_value;

   modport source (output valid, action, key, key_hash, new_value, input ready);
   modport sink   (input valid, action, key, key_hash, new_value, output ready);
endinterface

// Response channel: one word per request
interface oaht_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [oaht_pkg::STATUS_W-1:0]  status;
   logic [oaht_pkg::VALUE_W-1:0]   read_value;
   logic [oaht_pkg::LIVE_W-1:0]    live_entries;

   modport source (output valid, status, read_value, live_entries, input ready);
   modport sink   (input valid, status, read_value, live_entries, output ready);
endinterface

FILE: rtl/core/oaht_ram.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table: generic RAM
// One write port, one read port, registered read data held when not reading.
// ----------------------------------------------------------------------------
module oaht_ram #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: rtl/core/oaht_engine.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table: probe engine
// Walks the perturbed probe chain through the slot RAM, applies the
// operation, keeps the live and non-free counts and holds the response word.
// ----------------------------------------------------------------------------
module oaht_engine #(
   parameter int TABLE_SLOTS = 256,
   parameter int KW          = 32,
   parameter int VW          = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear_done,
   oaht_req_if.sink                              req_bus,
   oaht_rsp_if.source                            rsp_bus,
   output logic                                  mem_rd_en,
   output logic [$clog2(TABLE_SLOTS)-1:0]        mem_rd_addr,
   input  logic [oaht_pkg::MARK_W+KW+VW-1:0]     mem_rd_data,
   output logic                                  mem_wr_en,
   output logic [$clog2(TABLE_SLOTS)-1:0]        mem_wr_addr,
   output logic [oaht_pkg::MARK_W+KW+VW-1:0]     mem_wr_data
);

   localparam int AW    = $clog2(TABLE_SLOTS);
   localparam int CW    = $clog2(TABLE_SLOTS + 1);
   localparam int FW    = CW + 2;
   localparam int LIMIT = TABLE_SLOTS + 8;
   localparam int NW    = $clog2(LIMIT + 1);
   localparam int MW    = oaht_pkg::MARK_W + KW + VW;
   localparam logic [FW-1:0] FILL_LIMIT = FW'(2 * TABLE_SLOTS);
   localparam logic [NW-1:0] LAST_STEP  = NW'(LIMIT - 1);

   typedef enum logic {ST_IDLE, ST_PROBE} state_type;

   state_type                     state_ff, state_in;
   logic [oaht_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [KW-1:0]                 key_ff, key_in;
   logic [VW-1:0]                 value_ff, value_in;
   logic [AW-1:0]                 slot_ff, slot_in;
   logic [oaht_pkg::HASH_W-1:0]   perturb_ff, perturb_in;
   logic [NW-1:0]                 steps_ff, steps_in;
   logic                          tomb_seen_ff, tomb_seen_in;
   logic [AW-1:0]                 tomb_slot_ff, tomb_slot_in;
   logic [CW-1:0]                 live_ff, live_in;
   logic [CW-1:0]                 nonfree_ff, nonfree_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [oaht_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [oaht_pkg::VALUE_W-1:0]  read_value_ff, read_value_in;
   logic [oaht_pkg::LIVE_W-1:0]   live_out_ff, live_out_in;

   // Fields of the slot word returned by the RAM
   logic [oaht_pkg::MARK_W-1:0] slot_mark;
   logic [KW-1:0]               slot_key;
   logic [VW-1:0]               slot_value;
   assign slot_mark  = mem_rd_data[MW-1 -: oaht_pkg::MARK_W];
   assign slot_key   = mem_rd_data[KW+VW-1 -: KW];
   assign slot_value = mem_rd_data[VW-1:0];

   // Slot classification for the current probe step
   logic is_free, is_match, is_tomb, probe_end, rsp_free;
   logic have_tomb;
   logic [AW-1:0] tomb_pick, slot_next;
   logic [FW-1:0] fill_need;

   assign is_free   = (slot_mark == oaht_pkg::MARK_FREE);
   assign is_tomb   = (slot_mark == oaht_pkg::MARK_TOMB);
   assign is_match  = (slot_mark == oaht_pkg::MARK_TAKEN) && (slot_key == key_ff);
   assign probe_end = is_free || is_match || (steps_ff == LAST_STEP);
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign have_tomb = tomb_seen_ff || is_tomb;
   assign tomb_pick = tomb_seen_ff ? tomb_slot_ff : slot_ff;

   // next = 5*slot + perturb + 1, modulo table size
   assign slot_next = AW'({slot_ff, 2'b00}) + slot_ff + perturb_ff[AW-1:0] + AW'(1);

   // (nonfree + 1) * 3 against two thirds of the table
   assign fill_need = FW'({nonfree_ff, 1'b0}) + FW'(nonfree_ff) + FW'(3);

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      perturb_in    = perturb_ff;
      steps_in      = steps_ff;
      tomb_seen_in  = tomb_seen_ff;
      tomb_slot_in  = tomb_slot_ff;
      live_in       = live_ff;
      nonfree_in    = nonfree_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      status_in     = status_ff;
      read_value_in = read_value_ff;
      live_out_in   = live_out_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = slot_next;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_ff;
      mem_wr_data   = {oaht_pkg::MARK_TAKEN, key_ff, value_ff};

      case (state_ff)
         // Take a request word and read its home slot
         ST_IDLE: begin
            if (req_bus.valid && clear_done) begin
               action_in    = req_bus.action;
               key_in       = req_bus.key[KW-1:0];
               value_in     = req_bus.new_value[VW-1:0];
               slot_in      = req_bus.key_hash[AW-1:0];
               perturb_in   = req_bus.key_hash;
               steps_in     = '0;
               tomb_seen_in = 1'b0;
               mem_rd_en    = 1'b1;
               mem_rd_addr  = req_bus.key_hash[AW-1:0];
               state_in     = ST_PROBE;
            end
         end

         // Inspect the slot just read; step on or finish
         ST_PROBE: begin
            if (!probe_end) begin
               if (is_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_slot_in = slot_ff;
               end
               slot_in     = slot_next;
               perturb_in  = perturb_ff >> oaht_pkg::PERTURB_SHIFT;
               steps_in    = steps_ff + NW'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_next;
            end else if (rsp_free) begin
               status_in     = oaht_pkg::ST_NOT_FOUND;
               read_value_in = '0;
               case (action_ff)
                  oaht_pkg::ACT_GET: begin
                     if (is_match) begin
                        status_in     = oaht_pkg::ST_OK;
                        read_value_in = oaht_pkg::VALUE_W'(slot_value);
                     end
                  end
                  oaht_pkg::ACT_DELETE: begin
                     if (is_match) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {oaht_pkg::MARK_TOMB, slot_key, slot_value};
                        if (live_ff != '0) begin
                           live_in = live_ff - CW'(1);
                        end
                        status_in = oaht_pkg::ST_OK;
                     end
                  end
                  oaht_pkg::ACT_SET: begin
                     if (is_match) begin
                        mem_wr_en = 1'b1;
                        status_in = oaht_pkg::ST_OK;
                     end else if (have_tomb) begin
                        // reuse the first tombstone on the chain
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = tomb_pick;
                        live_in     = live_ff + CW'(1);
                        status_in   = oaht_pkg::ST_OK;
                     end else if (is_free && (fill_need <= FILL_LIMIT)) begin
                        mem_wr_en  = 1'b1;
                        live_in    = live_ff + CW'(1);
                        nonfree_in = nonfree_ff + CW'(1);
                        status_in  = oaht_pkg::ST_OK;
                     end else begin
                        status_in = oaht_pkg::ST_FULL;
                     end
                  end
                  default: begin
                     // undefined operation: no change, not found
                  end
               endcase
               live_out_in  = oaht_pkg::LIVE_W'(live_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State, counters and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         nonfree_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         nonfree_ff   <= nonfree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      perturb_ff    <= perturb_in;
      steps_ff      <= steps_in;
      tomb_seen_ff  <= tomb_seen_in;
      tomb_slot_ff  <= tomb_slot_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
      live_out_ff   <= live_out_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE) && clear_done;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.read_value   = read_value_ff;
   assign rsp_bus.live_entries = live_out_ff;

endmodule

FILE: rtl/core/open_addressing_hash_table_top.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table: top level
// Slot RAM, post-reset clearing sweep and the probe engine.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake      Word
//   req_bus   in    valid/ready    action, key, key_hash, new_value
//   rsp_bus   out   valid/ready    status, read_value, live_entries
//
// A request reads its home slot and then one further slot per step on its probe
// chain, each step one read of the slot RAM's single read port (at most
// TABLE_SLOTS + 8 slots). After reset a sweep marks every slot free, with
// req_bus.ready low. A held response word stalls only the finishing step;
// the next request is taken while the last response still waits.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top #(
   parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEFAULT,
   parameter int KEY_BITS    = oaht_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS  = oaht_pkg::VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   oaht_req_if.sink   req_bus,
   oaht_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int KW = (KEY_BITS < oaht_pkg::KEY_W) ? KEY_BITS : oaht_pkg::KEY_W;
   localparam int VW = (VALUE_BITS < oaht_pkg::VALUE_W) ? VALUE_BITS : oaht_pkg::VALUE_W;
   localparam int MW = oaht_pkg::MARK_W + KW + VW;
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

   logic          eng_rd_en, eng_wr_en;
   logic [AW-1:0] eng_rd_addr, eng_wr_addr;
   logic [MW-1:0] eng_wr_data, rd_data;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [MW-1:0] ram_wr_data;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clear_done_ff, clear_done_in;

   // Clearing sweep: one slot marked free per cycle after reset
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      clear_done_in = clear_done_ff;
      if (!clear_done_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_SLOT) begin
            clear_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         clear_done_ff <= 1'b0;
      end else begin
         clr_addr_ff   <= clr_addr_in;
         clear_done_ff <= clear_done_in;
      end
   end

   // Write port goes to the sweep until it is done
   assign ram_wr_en   = !clear_done_ff || eng_wr_en;
   assign ram_wr_addr = clear_done_ff ? eng_wr_addr : clr_addr_ff;
   assign ram_wr_data = clear_done_ff ? eng_wr_data : {oaht_pkg::MARK_FREE, (KW + VW)'(0)};

   oaht_ram #(
      .WIDTH (MW),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (eng_rd_en),
      .rd_addr (eng_rd_addr),
      .rd_data (rd_data)
   );

   oaht_engine #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KW          (KW),
      .VW          (VW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .clear_done  (clear_done_ff),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mem_rd_en   (eng_rd_en),
      .mem_rd_addr (eng_rd_addr),
      .mem_rd_data (rd_data),
      .mem_wr_en   (eng_wr_en),
      .mem_wr_addr (eng_wr_addr),
      .mem_wr_data (eng_wr_data)
   );

endmodule

FILE: tb/sv/open_addressing_hash_table_top_tb.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table: top-level testbench
// Drives get, set, delete and unassigned-code words into the table and checks every response
// word against a shadow table that replays the perturbed probe sequence,
// tombstone reuse and the two-thirds fill limit.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oaht_pkg::*;

   localparam int TABLE_SLOTS = TABLE_SLOTS_DEFAULT;
   localparam int PROBE_LIMIT = TABLE_SLOTS + 8;
   localparam int RANDOM_ITEMS = 1400;
   localparam int TAIL_ITEMS   = 120;   // last stretch runs without idling
   localparam int POOL_SIZE    = 64;
   localparam int HOLD_AFTER   = 400;   // long receiver hold-off starts here
   localparam int HOLD_CYCLES  = 80;

   // Unassigned operation code: the block must answer not found
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [HASH_W-1:0]   key_hash;
      logic [VALUE_W-1:0]  new_value;
   } lookup_word_t;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [LIVE_W-1:0]   live_entries;
   } answer_word_t;

   typedef struct {
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] key_hash;
   } known_key_t;

   logic clock;
   logic reset;

   oaht_req_if req_bus ();
   oaht_rsp_if rsp_bus ();

   open_addressing_hash_table_top #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BITS    (KEY_BITS_DEFAULT),
      .VALUE_BITS  (VALUE_BITS_DEFAULT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the table
   logic [MARK_W-1:0]  shadow_mark  [TABLE_SLOTS];
   logic [KEY_W-1:0]   shadow_key   [TABLE_SLOTS];
   logic [VALUE_W-1:0] shadow_value [TABLE_SLOTS];
   int unsigned        shadow_live;
   int unsigned        shadow_nonfree;

   lookup_word_t pending_lookups [$];
   answer_word_t awaited_answers [$];
   lookup_word_t offered;
   known_key_t   key_pool [POOL_SIZE];

   bit lookup_taken;
   int requests_taken;
   int answers_seen;
   int mismatch_count;
   int idle_left;
   int stall_left;
   int hold_left;
   bit long_hold_done;

   // What the run reached
   int get_hits, get_misses, deletes_done, tomb_reuses, full_refusals;
   int unsigned peak_live;

   // Replays one request on the shadow table and returns its answer
   function automatic answer_word_t apply_lookup(lookup_word_t w);
      int unsigned  slot, end_slot, tomb_slot, steps;
      logic [31:0]  perturb, next_slot;
      bit           matched, hit_free, have_tomb;
      answer_word_t a;

      a.status     = ST_NOT_FOUND;
      a.read_value = '0;
      matched   = 0;
      hit_free  = 0;
      have_tomb = 0;
      end_slot  = 0;
      tomb_slot = 0;
      if (w.action != ACT_UNUSED) begin
         slot    = w.key_hash & (TABLE_SLOTS - 1);
         perturb = w.key_hash;
         // walk the probe chain until a free slot, the key or the probe limit
         for (steps = 0; steps < PROBE_LIMIT && !matched && !hit_free; steps++) begin
            if (shadow_mark[slot] == MARK_FREE) begin
               hit_free = 1;
               end_slot = slot;
            end else if (shadow_mark[slot] == MARK_TOMB) begin
               if (!have_tomb) begin
                  have_tomb = 1;
                  tomb_slot = slot;
               end
            end else if (shadow_key[slot] == w.key) begin
               matched  = 1;
               end_slot = slot;
            end
            if (!matched && !hit_free) begin
               next_slot = 32'(5 * slot) + perturb + 32'd1;
               slot      = next_slot & (TABLE_SLOTS - 1);
               perturb   = perturb >> PERTURB_SHIFT;
            end
         end

         case (w.action)
            ACT_GET: begin
               if (matched) begin
                  a.status     = ST_OK;
                  a.read_value = shadow_value[end_slot];
                  get_hits++;
               end else begin
                  get_misses++;
               end
            end
            ACT_DELETE: begin
               if (matched) begin
                  shadow_mark[end_slot] = MARK_TOMB;
                  if (shadow_live > 0) shadow_live--;
                  a.status = ST_OK;
                  deletes_done++;
               end
            end
            default: begin
               if (matched) begin
                  shadow_value[end_slot] = w.new_value;
                  a.status = ST_OK;
               end else if (have_tomb) begin
                  // reuse the first tombstone on the chain
                  shadow_mark[tomb_slot]  = MARK_TAKEN;
                  shadow_key[tomb_slot]   = w.key;
                  shadow_value[tomb_slot] = w.new_value;
                  shadow_live++;
                  a.status = ST_OK;
                  tomb_reuses++;
               end else if (hit_free && (shadow_nonfree + 1) * 3 <= TABLE_SLOTS * 2) begin
                  shadow_mark[end_slot]  = MARK_TAKEN;
                  shadow_key[end_slot]   = w.key;
                  shadow_value[end_slot] = w.new_value;
                  shadow_live++;
                  shadow_nonfree++;
                  a.status = ST_OK;
               end else begin
                  a.status = ST_FULL;
                  full_refusals++;
               end
            end
         endcase
      end
      a.live_entries = shadow_live[LIVE_W-1:0];
      if (shadow_live > peak_live) peak_live = shadow_live;
      return a;
   endfunction

   function automatic void queue_lookup(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                                        logic [HASH_W-1:0] key_hash,
                                        logic [VALUE_W-1:0] new_value);
      lookup_word_t w;
      w.action    = action;
      w.key       = key;
      w.key_hash  = key_hash;
      w.new_value = new_value;
      pending_lookups.push_back(w);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      $display("[%0t] response %0d %s: expected 0x%0h, got 0x%0h",
               $realtime, answers_seen, what, want, got);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request side: take note of accepted words and predict their answers
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         awaited_answers.push_back(apply_lookup(offered));
         lookup_taken = 1;
         requests_taken++;
      end
   end

   // Request driver: holds a word until it is taken, idles in short bursts
   always @(negedge clock) begin
      if (reset !== 1'b0) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !lookup_taken)) begin
         lookup_taken = 0;
         if (idle_left > 0) begin
            idle_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_lookups.size() > TAIL_ITEMS && $urandom_range(0, 99) < 10) begin
            idle_left = $urandom_range(0, 4);
            req_bus.valid <= 1'b0;
         end else if (pending_lookups.size() != 0) begin
            offered = pending_lookups.pop_front();
            req_bus.action    <= offered.action;
            req_bus.key       <= offered.key;
            req_bus.key_hash  <= offered.key_hash;
            req_bus.new_value <= offered.new_value;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side: compare each word with the oldest prediction
   always @(posedge clock) begin
      answer_word_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen++;
         if (awaited_answers.size() == 0) begin
            report_mismatch("arrived unrequested, status", '0, 32'(rsp_bus.status));
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_bus.status));
            if (rsp_bus.read_value !== want.read_value)
               report_mismatch("read_value", want.read_value, rsp_bus.read_value);
            if (rsp_bus.live_entries !== want.live_entries)
               report_mismatch("live_entries", 32'(want.live_entries),
                               32'(rsp_bus.live_entries));
         end
      end
   end

   // Response ready: random stalls plus one long hold-off to back up the block
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && requests_taken >= HOLD_AFTER) begin
         long_hold_done = 1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (pending_lookups.size() > TAIL_ITEMS && $urandom_range(0, 99) < 12) begin
         stall_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("** open_addressing_hash_table_top: FAILED **");
      $finish;
   end

   // Stimulus and end of run
   initial begin : stimulus
      int          pick, idx, n;
      logic [31:0] fresh_key, fresh_hash;

      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_GET;
      req_bus.key       = '0;
      req_bus.key_hash  = '0;
      req_bus.new_value = '0;
      rsp_bus.ready     = 1'b0;
      lookup_taken   = 0;
      requests_taken = 0;
      answers_seen   = 0;
      mismatch_count = 0;
      idle_left      = 0;
      stall_left     = 0;
      hold_left      = 0;
      long_hold_done = 0;
      get_hits = 0; get_misses = 0; deletes_done = 0; tomb_reuses = 0; full_refusals = 0;
      peak_live      = 0;
      shadow_live    = 0;
      shadow_nonfree = 0;
      for (n = 0; n < TABLE_SLOTS; n++) shadow_mark[n] = MARK_FREE;

      // key pool: random hashes, with the second quarter colliding with the first
      for (n = 0; n < POOL_SIZE; n++) begin
         key_pool[n].key      = $urandom();
         key_pool[n].key_hash = $urandom();
      end
      for (n = POOL_SIZE / 4; n < POOL_SIZE / 2; n++) begin
         key_pool[n].key_hash[12:0] = key_pool[n - POOL_SIZE / 4].key_hash[12:0];
         if (n % 2 == 0) key_pool[n].key_hash[31:8] = '0;
      end

      // directed: empty table, extremes, update, collisions, tombstones
      queue_lookup(ACT_GET,    32'h0,        32'h0,        32'h0);
      queue_lookup(ACT_DELETE, 32'h0,        32'h0,        32'h0);
      queue_lookup(ACT_SET,    32'h0,        32'h0,        32'h0);
      queue_lookup(ACT_SET,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_lookup(ACT_GET,    32'h0,        32'h0,        32'h0);
      queue_lookup(ACT_GET,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
      queue_lookup(ACT_SET,    32'h0,        32'h0,        32'hA5A5A5A5);
      queue_lookup(ACT_GET,    32'h0,        32'h0,        32'h0);
      queue_lookup(ACT_SET,    32'h1,        32'h100,      32'h11111111);
      queue_lookup(ACT_SET,    32'h2,        32'h200,      32'h22222222);
      queue_lookup(ACT_DELETE, 32'h0,        32'h0,        32'hFFFFFFFF);
      queue_lookup(ACT_GET,    32'h1,        32'h100,      32'h0);
      queue_lookup(ACT_GET,    32'h0,        32'h0,        32'h0);
      queue_lookup(ACT_SET,    32'h3,        32'h0,        32'h33333333);
      queue_lookup(ACT_DELETE, 32'h1,        32'h100,      32'h0);
      queue_lookup(ACT_DELETE, 32'h1,        32'h100,      32'h0);
      queue_lookup(ACT_UNUSED, 32'h3,        32'h0,        32'hFFFFFFFF);
      queue_lookup(ACT_SET,    32'h5,        32'h80000000, 32'h55555555);
      queue_lookup(ACT_GET,    32'h5,        32'h7FFFFFFF, 32'h0);
      queue_lookup(ACT_GET,    32'h3,        32'h0,        32'h0);
      queue_lookup(ACT_GET,    32'h2,        32'h200,      32'h0);

      // random: mostly pool keys with consistent hashes, new keys to fill up
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            fresh_key  = $urandom();
            fresh_hash = $urandom();
            queue_lookup(ACT_SET, fresh_key, fresh_hash, $urandom());
            if ($urandom_range(0, 2) == 0) begin
               idx = $urandom_range(POOL_SIZE / 2, POOL_SIZE - 1);
               key_pool[idx].key      = fresh_key;
               key_pool[idx].key_hash = fresh_hash;
            end
         end else if (pick < 24) begin
            queue_lookup(ACTION_W'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
         end else if (pick < 28) begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            queue_lookup(ACTION_W'($urandom_range(0, 2)), key_pool[idx].key, $urandom(),
                         $urandom());
         end else begin
            idx  = $urandom_range(0, POOL_SIZE - 1);
            pick = $urandom_range(0, 99);
            queue_lookup(pick < 40 ? ACT_GET : (pick < 75 ? ACT_SET : ACT_DELETE),
                         key_pool[idx].key, key_pool[idx].key_hash, $urandom());
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: every word taken, every answer back, then a quiet margin
      while (pending_lookups.size() != 0 || req_bus.valid) @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (2 * PROBE_LIMIT) @(posedge clock);

      $display("Covered %0d requests: %0d get hits, %0d get misses, %0d deletes",
               requests_taken, get_hits, get_misses, deletes_done);
      $display("Tombstones reused %0d times, %0d inserts refused as full, peak live %0d",
               tomb_reuses, full_refusals, peak_live);
      if (mismatch_count == 0) begin
         $display("** open_addressing_hash_table_top: PASSED **");
      end else begin
         $display("** open_addressing_hash_table_top: FAILED **");
      end
      $finish;
   end

endmodule
